@@ rtl/png_stored_stream_encoder_macros.svh @@
// Assertion macros shared by the checker. Both sample on clk and are disabled during rst.
`ifndef PNG_STORED_STREAM_ENCODER_MACROS_SVH
`define PNG_STORED_STREAM_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("png encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("png encoder check failed");

`endif

@@ rtl/pse_pkg.sv @@
package pse_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [16:0] BLOCK_MAX = 17'd65535;

  // Byte sources for the output multiplexer.
  localparam logic [3:0] SRC_LIT    = 4'd0;
  localparam logic [3:0] SRC_WIDTH  = 4'd1;
  localparam logic [3:0] SRC_HEIGHT = 4'd2;
  localparam logic [3:0] SRC_COLOR  = 4'd3;
  localparam logic [3:0] SRC_CRCINV = 4'd4;
  localparam logic [3:0] SRC_IDAT   = 4'd5;
  localparam logic [3:0] SRC_BHDR   = 4'd6;
  localparam logic [3:0] SRC_PIX    = 4'd7;
  localparam logic [3:0] SRC_ADLER  = 4'd8;

  typedef struct packed {
    logic       fire;      // a byte is loaded into the output register this cycle
    logic [3:0] src;
    logic [2:0] idx;       // byte within a word (MSB first) or block header byte
    logic [7:0] lit;
    logic       crc_upd;
    logic       crc_init;
    logic       raw;       // byte belongs to the zlib raw stream
    logic       pix;       // raw byte is a pixel byte
    logic       bh_done;   // last byte of a stored block header
    logic       last;
    logic       excess;
    logic       start;     // latch geometry and clear the image state
    logic       pix_load;  // capture the incoming pixel byte
    logic       fin_done;
  } pse_cmd_t;

  typedef struct packed {
    logic active;
    logic row_start;
    logic block_full;
    logic done_next;
  } pse_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/png_stored_stream_encoder.sv @@
// The first result of a transaction is loaded into the output register from the state that
// the sequencer enters on accepting it, as soon as the output register can take a byte.
// Throughput: one output byte per cycle while the output is not stalled; a transaction holds
// the input until its last byte is loaded, and a new one is accepted only once the sequencer
// is back in its idle state.
// Reset (synchronous, rst high) returns the sequencer to idle, drops any image in progress,
// empties the output register and sets the registers to width 1, height 1, grey.
module png_stored_stream_encoder #(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        excess_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pse_pkg::*;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RGBA   = 2'd2;

  logic [14:0] image_width, image_height;
  logic        rgba_mode;
  logic        busy;
  logic        load_ok;
  pse_cmd_t    cmd;
  pse_status_t status;

  // Configuration registers. Writes land on the access phase; geometry is
  // latched by the datapath when a start transaction is accepted.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 15'd1;
      image_height <= 15'd1;
      rgba_mode    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[14:0];
        REG_HEIGHT: image_height <= pwdata[14:0];
        REG_RGBA:   rgba_mode    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {17'd0, image_width};
      REG_HEIGHT: prdata = {17'd0, image_height};
      REG_RGBA:   prdata = {31'd0, rgba_mode};
      default:    prdata = 32'd0;
    endcase
  end

  // The input side is open only while the sequencer is idle, so each
  // transaction runs to its last byte before the next one is taken.
  assign in_stall = busy;

  // The output register may take a new byte when it is empty or being drained.
  assign load_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  pse_control u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .load_ok  (load_ok),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath keeps the CRC-32, Adler-32, stream counters and the
  // output byte register; it acts only on the controller's commands.
  pse_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_width   (image_width),
    .cfg_height  (image_height),
    .cfg_rgba    (rgba_mode),
    .pixel_byte  (pixel_byte),
    .status      (status),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .excess_byte (excess_byte)
  );

endmodule

@@ rtl/pse_datapath.sv @@
module pse_datapath #(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  pse_pkg::pse_cmd_t   cmd,
  input  logic [14:0]         cfg_width,
  input  logic [14:0]         cfg_height,
  input  logic                cfg_rgba,
  input  logic [7:0]          pixel_byte,
  output pse_pkg::pse_status_t status,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                excess_byte
);
  import pse_pkg::*;

  logic [31:0] crc;
  logic [15:0] adl_lo, adl_hi;
  logic [31:0] raw_count, raw_total, idat_len;
  logic [17:0] row_count, stride;
  logic [15:0] block_fill;
  logic [15:0] w_lat, h_lat;
  logic        rgba_lat;
  logic [7:0]  pix;
  logic        active;

  logic [15:0] w_c, h_c;
  logic [17:0] stride_c;
  logic [34:0] prod;
  logic [16:0] split_sum, split_rem;
  logic [1:0]  split_k;
  logic [31:0] blocks;
  logic [31:0] left;
  logic        bh_last;
  logic [15:0] bh_len;
  logic [31:0] word;
  logic [7:0]  word_byte, cur;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_new, hi_new;

  // Geometry at start: zero reads as one, large values saturate at the bound.
  always_comb begin
    if (cfg_width == 15'd0) w_c = 16'd1;
    else if (32'(cfg_width) > 32'(MAX_WIDTH)) w_c = 16'(MAX_WIDTH);
    else w_c = {1'b0, cfg_width};
    if (cfg_height == 15'd0) h_c = 16'd1;
    else if (32'(cfg_height) > 32'(MAX_HEIGHT)) h_c = 16'(MAX_HEIGHT);
    else h_c = {1'b0, cfg_height};
    stride_c = cfg_rgba ? {w_c, 2'b00} : {2'b00, w_c};
    prod     = 35'({1'b0, stride_c} + 19'd1) * 35'(h_c);
  end

  // Stored block count: ceil(raw_total / 65535), using 2^16 = 65535 + 1.
  always_comb begin
    split_sum = {1'b0, raw_total[31:16]} + {1'b0, raw_total[15:0]};
    if (split_sum >= {BLOCK_MAX[15:0], 1'b0}) begin
      split_k   = 2'd2;
      split_rem = split_sum - {BLOCK_MAX[15:0], 1'b0};
    end else if (split_sum >= BLOCK_MAX) begin
      split_k   = 2'd1;
      split_rem = split_sum - BLOCK_MAX;
    end else begin
      split_k   = 2'd0;
      split_rem = split_sum;
    end
    blocks = {16'd0, raw_total[31:16]} + {30'd0, split_k} + {31'd0, (split_rem != 17'd0)};
  end

  always_comb begin
    left    = raw_total - raw_count;
    bh_last = (left <= {15'd0, BLOCK_MAX});
    bh_len  = bh_last ? left[15:0] : BLOCK_MAX[15:0];
  end

  always_comb begin
    case (cmd.src)
      SRC_WIDTH:  word = {16'd0, w_lat};
      SRC_HEIGHT: word = {16'd0, h_lat};
      SRC_CRCINV: word = ~crc;
      SRC_IDAT:   word = idat_len;
      SRC_ADLER:  word = {adl_hi, adl_lo};
      default:    word = 32'd0;
    endcase
    case (cmd.idx[1:0])
      2'd0:    word_byte = word[31:24];
      2'd1:    word_byte = word[23:16];
      2'd2:    word_byte = word[15:8];
      default: word_byte = word[7:0];
    endcase
    case (cmd.src)
      SRC_LIT:   cur = cmd.lit;
      SRC_COLOR: cur = rgba_lat ? 8'd6 : 8'd0;
      SRC_PIX:   cur = pix;
      SRC_BHDR: begin
        case (cmd.idx)
          3'd0:    cur = {7'd0, bh_last};
          3'd1:    cur = bh_len[7:0];
          3'd2:    cur = bh_len[15:8];
          3'd3:    cur = ~bh_len[7:0];
          default: cur = ~bh_len[15:8];
        endcase
      end
      default:   cur = word_byte;
    endcase
  end

  always_comb begin
    lo_sum = {1'b0, adl_lo} + {9'd0, cur};
    lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, adl_hi} + {1'b0, lo_new};
    hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  always_comb begin
    status.active     = active;
    status.row_start  = (row_count == 18'd0);
    status.block_full = (block_fill == BLOCK_MAX[15:0]);
    status.done_next  = ((raw_count + 32'd1) >= raw_total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.start) begin
      active <= 1'b1;
    end else if (cmd.fire && cmd.fin_done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idat_len <= raw_total + 32'((blocks << 2) + blocks) + 32'd6;
    if (cmd.pix_load) begin
      pix <= pixel_byte;
    end
    if (cmd.start) begin
      w_lat      <= w_c;
      h_lat      <= h_c;
      rgba_lat   <= cfg_rgba;
      stride     <= stride_c;
      raw_total  <= prod[31:0];
      raw_count  <= 32'd0;
      row_count  <= 18'd0;
      block_fill <= 16'd0;
      adl_lo     <= 16'd1;
      adl_hi     <= 16'd0;
    end else if (cmd.fire) begin
      if (cmd.raw) begin
        adl_lo     <= lo_new;
        adl_hi     <= hi_new;
        raw_count  <= raw_count + 32'd1;
        block_fill <= block_fill + 16'd1;
        if (cmd.pix) begin
          row_count <= ((row_count + 18'd1) >= stride) ? 18'd0 : row_count + 18'd1;
        end
      end else if (cmd.bh_done) begin
        block_fill <= 16'd0;
      end
    end
    if (cmd.fire) begin
      if (cmd.crc_init) crc <= CRC_INIT;
      else if (cmd.crc_upd) crc <= crc_byte(crc, cur);
      out_byte    <= cur;
      run_last    <= cmd.last;
      excess_byte <= cmd.excess;
    end
  end

endmodule

@@ rtl/pse_control.sv @@
module pse_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                func,
  input  logic                load_ok,
  input  pse_pkg::pse_status_t status,
  output pse_pkg::pse_cmd_t   cmd,
  output logic                busy
);
  import pse_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_EXC  = 3'd2;
  localparam logic [2:0] ST_RAW  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [5:0] HDR_LAST = 6'd47;
  localparam logic [5:0] FIN_LAST = 6'd19;
  localparam logic [5:0] BH_LAST  = 6'd4;

  logic [2:0] state, state_next;
  logic [5:0] step, step_next;
  logic       is_pix, is_pix_next;

  function automatic pse_cmd_t word_entry(input logic [3:0] src, input logic [5:0] off,
                                          input logic crc_upd);
    pse_cmd_t c;
    c         = '0;
    c.src     = src;
    c.idx     = {1'b0, off[1:0]};
    c.crc_upd = crc_upd;
    return c;
  endfunction

  function automatic pse_cmd_t lit_entry(input logic [7:0] v, input logic crc_upd);
    pse_cmd_t c;
    c         = '0;
    c.src     = SRC_LIT;
    c.lit     = v;
    c.crc_upd = crc_upd;
    return c;
  endfunction

  function automatic pse_cmd_t hdr_entry(input logic [5:0] s);
    pse_cmd_t c;
    case (s)
      6'd0:  c = lit_entry(8'h89, 1'b0);
      6'd1:  c = lit_entry(8'h50, 1'b0);
      6'd2:  c = lit_entry(8'h4E, 1'b0);
      6'd3:  c = lit_entry(8'h47, 1'b0);
      6'd4:  c = lit_entry(8'h0D, 1'b0);
      6'd5:  c = lit_entry(8'h0A, 1'b0);
      6'd6:  c = lit_entry(8'h1A, 1'b0);
      6'd7:  c = lit_entry(8'h0A, 1'b0);
      6'd8, 6'd9, 6'd10: c = lit_entry(8'h00, 1'b0);
      6'd11: c = lit_entry(8'h0D, 1'b0);
      6'd12: c = lit_entry(8'h49, 1'b1);
      6'd13: c = lit_entry(8'h48, 1'b1);
      6'd14: c = lit_entry(8'h44, 1'b1);
      6'd15: c = lit_entry(8'h52, 1'b1);
      6'd16, 6'd17, 6'd18, 6'd19: c = word_entry(SRC_WIDTH, s, 1'b1);
      6'd20, 6'd21, 6'd22, 6'd23: c = word_entry(SRC_HEIGHT, s, 1'b1);
      6'd24: c = lit_entry(8'h08, 1'b1);
      6'd25: c = word_entry(SRC_COLOR, s, 1'b1);
      6'd26, 6'd27, 6'd28: c = lit_entry(8'h00, 1'b1);
      6'd29, 6'd30, 6'd31, 6'd32: c = word_entry(SRC_CRCINV, s - 6'd1, 1'b0);
      6'd33, 6'd34, 6'd35, 6'd36: c = word_entry(SRC_IDAT, s - 6'd1, 1'b0);
      6'd37: c = lit_entry(8'h49, 1'b1);
      6'd38: c = lit_entry(8'h44, 1'b1);
      6'd39: c = lit_entry(8'h41, 1'b1);
      6'd40: c = lit_entry(8'h54, 1'b1);
      6'd41: c = lit_entry(8'h78, 1'b1);
      6'd42: c = lit_entry(8'h01, 1'b1);
      default: begin
        c         = '0;
        c.src     = SRC_BHDR;
        c.idx     = 3'(s - 6'd43);
        c.crc_upd = 1'b1;
      end
    endcase
    // The running CRC restarts on a plain byte ahead of each chunk type.
    c.crc_init = (s == 6'd8) || (s == 6'd33);
    return c;
  endfunction

  function automatic pse_cmd_t fin_entry(input logic [5:0] s);
    pse_cmd_t c;
    case (s)
      6'd0, 6'd1, 6'd2, 6'd3:     c = word_entry(SRC_ADLER, s, 1'b1);
      6'd4, 6'd5, 6'd6, 6'd7:     c = word_entry(SRC_CRCINV, s, 1'b0);
      6'd8, 6'd9, 6'd10, 6'd11:   c = lit_entry(8'h00, 1'b0);
      6'd12: c = lit_entry(8'h49, 1'b1);
      6'd13: c = lit_entry(8'h45, 1'b1);
      6'd14: c = lit_entry(8'h4E, 1'b1);
      6'd15: c = lit_entry(8'h44, 1'b1);
      default: c = word_entry(SRC_CRCINV, s, 1'b0);
    endcase
    c.crc_init = (s == 6'd8);
    return c;
  endfunction

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    step_next   = step;
    is_pix_next = is_pix;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          step_next = 6'd0;
          if (!func) begin
            cmd.start  = 1'b1;
            state_next = ST_HDR;
          end else if (status.active) begin
            cmd.pix_load = 1'b1;
            is_pix_next  = !status.row_start;
            state_next   = ST_RAW;
          end else begin
            state_next = ST_EXC;
          end
        end
      end
      ST_HDR: begin
        cmd      = hdr_entry(step);
        cmd.last = (step == HDR_LAST);
        cmd.fire = load_ok;
        if (load_ok) begin
          step_next = step + 6'd1;
          if (step == HDR_LAST) state_next = ST_IDLE;
        end
      end
      ST_EXC: begin
        cmd        = lit_entry(8'h00, 1'b0);
        cmd.excess = 1'b1;
        cmd.last   = 1'b1;
        cmd.fire   = load_ok;
        if (load_ok) state_next = ST_IDLE;
      end
      ST_RAW: begin
        if (status.block_full) begin
          cmd.src     = SRC_BHDR;
          cmd.idx     = step[2:0];
          cmd.crc_upd = 1'b1;
          cmd.bh_done = (step == BH_LAST);
          if (load_ok) step_next = (step == BH_LAST) ? 6'd0 : step + 6'd1;
        end else if (!is_pix) begin
          cmd     = lit_entry(8'h00, 1'b1);
          cmd.raw = 1'b1;
          if (load_ok) is_pix_next = 1'b1;
        end else begin
          cmd.src     = SRC_PIX;
          cmd.crc_upd = 1'b1;
          cmd.raw     = 1'b1;
          cmd.pix     = 1'b1;
          cmd.last    = !status.done_next;
          if (load_ok) begin
            step_next  = 6'd0;
            state_next = status.done_next ? ST_FIN : ST_IDLE;
          end
        end
        cmd.fire = load_ok;
      end
      ST_FIN: begin
        cmd          = fin_entry(step);
        cmd.last     = (step == FIN_LAST);
        cmd.fin_done = (step == FIN_LAST);
        cmd.fire     = load_ok;
        if (load_ok) begin
          step_next = step + 6'd1;
          if (step == FIN_LAST) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= 6'd0;
      is_pix <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      is_pix <= is_pix_next;
    end
  end

endmodule

@@ rtl/pse_checker.sv @@
`include "png_stored_stream_encoder_macros.svh"

module pse_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       excess_byte
);

  // A stalled result stays put.
  `PSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last))
  // Every accepted transaction produces output, so the input closes right after it.
  `PSE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A dropped pixel gives a single zero byte.
  `PSE_ASSERT_NOW(a_excess_form, out_valid && excess_byte, run_last && (out_byte == 8'h00))

endmodule

bind png_stored_stream_encoder pse_checker u_pse_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .run_last    (run_last),
  .excess_byte (excess_byte)
);
